// ===== rtl/sha1bs_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1bs_pkg
// Shared types, constants and round functions of the SHA-1 byte-stream unit.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

	localparam int unsigned NUM_WORDS   = 5;
	localparam int unsigned RING_DEPTH  = 16;
	localparam int unsigned NUM_ROUNDS  = 80;
	localparam int unsigned LEN_POS     = 56;

	typedef logic [31:0] word_t;
	typedef logic [6:0]  round_t;
	typedef logic [5:0]  pos_t;
	typedef logic [2:0]  sel_t;
	typedef logic [60:0] count_t;

	localparam word_t IV [NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam word_t K_00_19 = 32'h5A827999;
	localparam word_t K_20_39 = 32'h6ED9EBA1;
	localparam word_t K_40_59 = 32'h8F1BBCDC;
	localparam word_t K_60_79 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam round_t LAST_ROUND   = 7'(NUM_ROUNDS - 1);
	localparam round_t FIRST_EXPAND = 7'(RING_DEPTH);
	localparam pos_t   LAST_POS     = 6'd63;
	localparam pos_t   LEN_START    = 6'(LEN_POS);
	localparam sel_t   LAST_SEL     = 3'(NUM_WORDS - 1);

	typedef struct packed {
		logic       push;
		logic [7:0] data;
		logic [1:0] lane;
		logic       shift;
		logic       expand;
	} sched_ctrl_t;

	typedef struct packed {
		logic   load;
		logic   step;
		logic   add;
		logic   init;
		round_t t;
		sel_t   sel;
	} core_ctrl_t;

	function automatic word_t round_f(round_t t, word_t b, word_t c, word_t d);
		word_t f;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t < 7'd40) begin
			f = b ^ c ^ d;
		end else if (t < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic word_t round_k(round_t t);
		word_t k;
		if (t < 7'd20) begin
			k = K_00_19;
		end else if (t < 7'd40) begin
			k = K_20_39;
		end else if (t < 7'd60) begin
			k = K_40_59;
		end else begin
			k = K_60_79;
		end
		return k;
	endfunction

endpackage

// ===== rtl/sha1_byte_stream_hash_unit.sv =====
// ----------------------------------------------------------------------------
// sha1_byte_stream_hash_unit
// SHA-1 over a byte stream. The transaction that fills a 64-byte block is
// followed by 80 rounds on the shared round unit and the chaining add. On
// end_of_message the sequencer feeds padding and length one byte per cycle,
// then runs the compression, or pads and compresses a second block when one
// is needed; the five digest words then follow, h0 first, one per output
// transaction. in_ready is low throughout this work and while the digest is
// being read.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hash_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic        digest_last
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PAD   = 5'b00010,
		S_ROUND = 5'b00100,
		S_ADD   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t                 state_q;
	sha1bs_pkg::round_t     round_q;
	sha1bs_pkg::pos_t       pos_q;
	sha1bs_pkg::count_t     count_q;
	sha1bs_pkg::sel_t       sel_q;
	logic                   pad_first_q;
	logic                   len_here_q;
	logic                   then_pad_q;
	logic                   then_out_q;

	sha1bs_pkg::sched_ctrl_t sched_ctrl;
	sha1bs_pkg::core_ctrl_t  core_ctrl;
	sha1bs_pkg::word_t       w;
	logic                    in_acc;
	logic                    out_acc;
	logic                    len_here;
	logic [63:0]             len_bits;
	logic [7:0]              len_byte;
	logic [7:0]              pad_byte;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	assign len_bits = {count_q, 3'b000};
	assign len_byte = len_bits[{3'd7 - pos_q[2:0], 3'b000} +: 8];
	assign len_here = pad_first_q ? (pos_q < sha1bs_pkg::LEN_START) : len_here_q;

	always_comb begin
		priority if (pad_first_q) begin
			pad_byte = sha1bs_pkg::PAD_BYTE;
		end else if (len_here_q && (pos_q >= sha1bs_pkg::LEN_START)) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		sched_ctrl.push   = (in_acc && has_byte) || (state_q == S_PAD);
		sched_ctrl.data   = (state_q == S_PAD) ? pad_byte : data_byte;
		sched_ctrl.lane   = pos_q[1:0];
		sched_ctrl.shift  = (state_q == S_ROUND);
		sched_ctrl.expand = (round_q >= sha1bs_pkg::FIRST_EXPAND);

		core_ctrl.load = ((in_acc && has_byte) || (state_q == S_PAD))
		               && (pos_q == sha1bs_pkg::LAST_POS);
		core_ctrl.step = (state_q == S_ROUND);
		core_ctrl.add  = (state_q == S_ADD);
		core_ctrl.init = out_acc && (sel_q == sha1bs_pkg::LAST_SEL);
		core_ctrl.t    = round_q;
		core_ctrl.sel  = sel_q;
	end

	sha1bs_sched u_sched (
		.clk  (clk),
		.ctrl (sched_ctrl),
		.w    (w)
	);

	sha1bs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (core_ctrl),
		.w      (w),
		.digest (digest_word)
	);

	assign digest_last = (sel_q == sha1bs_pkg::LAST_SEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			round_q     <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			sel_q       <= '0;
			pad_first_q <= 1'b0;
			len_here_q  <= 1'b0;
			then_pad_q  <= 1'b0;
			then_out_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (has_byte) begin
							pos_q   <= pos_q + 6'd1;
							count_q <= count_q + 61'd1;
						end
						if (has_byte && (pos_q == sha1bs_pkg::LAST_POS)) begin
							state_q    <= S_ROUND;
							round_q    <= '0;
							then_pad_q <= end_of_message;
							then_out_q <= 1'b0;
							pad_first_q <= end_of_message;
						end else if (end_of_message) begin
							state_q     <= S_PAD;
							pad_first_q <= 1'b1;
						end
					end
				end
				S_PAD: begin
					pos_q       <= pos_q + 6'd1;
					pad_first_q <= 1'b0;
					len_here_q  <= len_here;
					if (pos_q == sha1bs_pkg::LAST_POS) begin
						state_q    <= S_ROUND;
						round_q    <= '0;
						then_pad_q <= !len_here;
						then_out_q <= len_here;
					end
				end
				S_ROUND: begin
					if (round_q == sha1bs_pkg::LAST_ROUND) begin
						state_q <= S_ADD;
						round_q <= '0;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				S_ADD: begin
					priority if (then_out_q) begin
						state_q <= S_OUT;
						sel_q   <= '0;
					end else if (then_pad_q) begin
						state_q <= S_PAD;
						// second block after an overflowed pad: length goes here; after a full last block pad_first_q decides
						len_here_q <= !pad_first_q;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						if (sel_q == sha1bs_pkg::LAST_SEL) begin
							state_q    <= S_IDLE;
							sel_q      <= '0;
							count_q    <= '0;
							pos_q      <= '0;
							len_here_q <= 1'b0;
						end else begin
							sel_q <= sel_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sha1bs_sched.sv =====
// ----------------------------------------------------------------------------
// sha1bs_sched
// Byte packer and 16-word schedule shift line; expands W[t] from round 16 on.
// ----------------------------------------------------------------------------
module sha1bs_sched (
	input  logic                    clk,
	input  sha1bs_pkg::sched_ctrl_t ctrl,
	output sha1bs_pkg::word_t       w
);

	logic [23:0]       part_q;
	sha1bs_pkg::word_t line_q [sha1bs_pkg::RING_DEPTH];
	sha1bs_pkg::word_t mix;
	sha1bs_pkg::word_t next_w;

	// slot 0 holds W[t-16], slot 15 holds W[t-1]
	assign mix    = line_q[13] ^ line_q[8] ^ line_q[2] ^ line_q[0];
	assign next_w = ctrl.expand ? {mix[30:0], mix[31]} : line_q[0];
	assign w      = next_w;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			part_q <= {part_q[15:0], ctrl.data};
		end
		if ((ctrl.push && (ctrl.lane == 2'd3)) || ctrl.shift) begin
			for (int i = 0; i < sha1bs_pkg::RING_DEPTH - 1; i++) begin
				line_q[i] <= line_q[i + 1];
			end
			line_q[sha1bs_pkg::RING_DEPTH - 1] <= ctrl.shift ? next_w : {part_q, ctrl.data};
		end
	end

endmodule

// ===== rtl/sha1bs_core.sv =====
// ----------------------------------------------------------------------------
// sha1bs_core
// Shared round unit: working words a..e, chaining words and digest select.
// ----------------------------------------------------------------------------
module sha1bs_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha1bs_pkg::core_ctrl_t ctrl,
	input  sha1bs_pkg::word_t      w,
	output sha1bs_pkg::word_t      digest
);

	sha1bs_pkg::word_t chain_q [sha1bs_pkg::NUM_WORDS];
	sha1bs_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	sha1bs_pkg::word_t tmp;

	assign tmp = {a_q[26:0], a_q[31:27]} + sha1bs_pkg::round_f(ctrl.t, b_q, c_q, d_q)
	           + e_q + sha1bs_pkg::round_k(ctrl.t) + w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= '0;
		end else if (ctrl.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (ctrl.step) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha1bs_pkg::NUM_WORDS; i++) begin
				chain_q[i] <= sha1bs_pkg::IV[i];
			end
		end else if (ctrl.init) begin
			for (int i = 0; i < sha1bs_pkg::NUM_WORDS; i++) begin
				chain_q[i] <= sha1bs_pkg::IV[i];
			end
		end else if (ctrl.add) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	always_comb begin
		unique case (ctrl.sel)
			3'd0:    digest = chain_q[0];
			3'd1:    digest = chain_q[1];
			3'd2:    digest = chain_q[2];
			3'd3:    digest = chain_q[3];
			3'd4:    digest = chain_q[4];
			default: digest = '0;
		endcase
	end

endmodule
